FILE: design/bslp_pkg.sv
// ----------------------------------------------------------------------------
// bslp_pkg: shared types and constants for the button press detector
// Register indexes, event codes, press state encoding, configuration bundle.
// ----------------------------------------------------------------------------
package bslp_pkg;

   // default width of the press timer
   localparam int TIMER_BITS_DEF = 16;

   // register field widths and reset values
   localparam int PERIOD_BITS  = 7;
   localparam int LONG_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 16;
   localparam int EVENT_BITS   = 2;

   localparam logic [PERIOD_BITS-1:0] RESET_PERIOD = 7'd10;
   localparam logic [LONG_BITS-1:0]   RESET_LONG   = 16'd1000;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG   = 2'd2;

   // press event codes
   localparam logic [EVENT_BITS-1:0] EV_NONE  = 2'd0;
   localparam logic [EVENT_BITS-1:0] EV_SHORT = 2'd1;
   localparam logic [EVENT_BITS-1:0] EV_LONG  = 2'd2;

   // press state machine
   typedef enum logic [1:0] {
      MODE_INIT         = 2'd0,
      MODE_WAIT_PRESS   = 2'd1,
      MODE_PRESSED      = 2'd2,
      MODE_WAIT_RELEASE = 2'd3
   } mode_type;

   // configuration bundle from the register block to the engine
   typedef struct packed {
      logic                   enable;
      logic [PERIOD_BITS-1:0] period;
      logic [LONG_BITS-1:0]   long_ms;
      logic                   period_wr;
   } cfg_type;

endpackage

FILE: design/button_short_long_press_detector_top.sv
// ----------------------------------------------------------------------------
// button_short_long_press_detector_top: debounced short/long press detector
// One tick beat in, one press event beat out.
//
//   channel | direction | beat carries
//   req_    | in        | pin_level (active low pin sample, one per tick)
//   rsp_    | out       | press_event (none, short, long)
//   csr_    | in        | index, data (enable, sample period, long time)
//
// Every tick passes from req_ beat to rsp_ beat through an input
// register, then the phase/timer/state update into the result register.
// One tick per cycle is sustained; ready drops when the result is stalled or
// a period write is handled: the phase is then reduced by shift and subtract,
// during which no tick or register write is taken. Reset is synchronous but leaves the pin sample and event data.
// ----------------------------------------------------------------------------
module button_short_long_press_detector_top #(
   parameter int TIMER_BITS = bslp_pkg::TIMER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_pin_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bslp_pkg::EVENT_BITS-1:0]     rsp_press_event,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bslp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bslp_pkg::CSR_DAT_BITS-1:0]   csr_data
);
   import bslp_pkg::*;

   cfg_type cfg;
   logic    busy;
   logic    item_take;
   logic    in_valid_ff, in_valid_in;
   logic    in_pin_ff, in_pin_in;

   // input register
   assign req_ready = !in_valid_ff || item_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_pin_in   = in_pin_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_pin_in   = req_pin_level;
      end else if (item_take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      in_pin_ff <= in_pin_in;
   end

   // configuration registers
   bslp_csr_regs u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .engine_busy (busy),
      .cfg         (cfg)
   );

   // detection engine
   bslp_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .item_valid      (in_valid_ff),
      .item_pin_level  (in_pin_ff),
      .item_take       (item_take),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_press_event (rsp_press_event)
   );

endmodule

FILE: design/bslp_csr_regs.sv
// ----------------------------------------------------------------------------
// bslp_csr_regs: configuration registers
// Holds enable, sample period and long-press time; flags period writes.
// ----------------------------------------------------------------------------
module bslp_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bslp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bslp_pkg::CSR_DAT_BITS-1:0]   csr_data,
   input  logic                                engine_busy,
   output bslp_pkg::cfg_type                   cfg
);
   import bslp_pkg::*;

   logic                   enable_ff, enable_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [LONG_BITS-1:0]   long_ff, long_in;
   logic                   period_wr_ff, period_wr_in;
   logic                   wr_beat;

   // no writes while the phase is being reduced
   assign csr_ready = !engine_busy && !period_wr_ff;
   assign wr_beat   = csr_valid && csr_ready;

   // register write decode
   always_comb begin
      enable_in    = enable_ff;
      period_in    = period_ff;
      long_in      = long_ff;
      period_wr_in = 1'b0;
      if (wr_beat) begin
         unique case (csr_index)
            CSR_ENABLE: enable_in = csr_data[0];
            CSR_PERIOD: begin
               period_in    = csr_data[PERIOD_BITS-1:0];
               period_wr_in = 1'b1;
            end
            CSR_LONG:   long_in = csr_data[LONG_BITS-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         period_ff    <= RESET_PERIOD;
         long_ff      <= RESET_LONG;
         period_wr_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         period_ff    <= period_in;
         long_ff      <= long_in;
         period_wr_ff <= period_wr_in;
      end
   end

   assign cfg.enable    = enable_ff;
   assign cfg.period    = period_ff;
   assign cfg.long_ms   = long_ff;
   assign cfg.period_wr = period_wr_ff;

endmodule

FILE: design/bslp_engine.sv
// ----------------------------------------------------------------------------
// bslp_engine: per-tick press detection
// Phase counter, press timer, press state machine and result register.
// The phase is kept reduced modulo the period; a period write starts a
// short shift-and-subtract pass that brings it back into range.
// ----------------------------------------------------------------------------
module bslp_engine #(
   parameter int TIMER_BITS = bslp_pkg::TIMER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bslp_pkg::cfg_type                 cfg,
   input  logic                              item_valid,
   input  logic                              item_pin_level,
   output logic                              item_take,
   output logic                              busy,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bslp_pkg::EVENT_BITS-1:0]   rsp_press_event
);
   import bslp_pkg::*;

   localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;
   localparam int SHIFT_BITS = $clog2(PERIOD_BITS);
   localparam int WIDE_BITS  = 2 * PERIOD_BITS;

   logic [PERIOD_BITS-1:0] phase_ff, phase_in;
   logic                   pending_ff, pending_in;
   logic [TIMER_BITS-1:0]  timer_ff, timer_in;
   mode_type               mode_ff, mode_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [EVENT_BITS-1:0]  event_ff, event_in;
   logic                   norm_ff, norm_in;
   logic [SHIFT_BITS-1:0]  shift_ff, shift_in;

   logic [PERIOD_BITS-1:0] period_eff;
   logic [PERIOD_BITS:0]   phase_inc;
   logic [PERIOD_BITS-1:0] phase_next;
   logic                   pending_next;
   logic [TIMER_BITS-1:0]  timer_next;
   logic [TIMER_BITS-1:0]  timer_load;
   logic [32:0]            long_wide;
   logic                   step;
   logic                   pressed;
   logic [WIDE_BITS-1:0]   trial;
   logic [EVENT_BITS-1:0]  ev;

   // no tick is taken while a period write is pending or being reduced
   assign busy      = norm_ff;
   assign item_take = item_valid && !norm_ff && !cfg.period_wr &&
                      (!rsp_valid_ff || rsp_ready);
   assign pressed   = !item_pin_level;

   // zero period acts as one
   assign period_eff = (cfg.period == '0) ? PERIOD_BITS'(1) : cfg.period;

   // phase, pending flag and timer for this tick
   always_comb begin
      phase_inc    = {1'b0, phase_ff} + (PERIOD_BITS+1)'(1);
      phase_next   = (phase_inc >= {1'b0, period_eff}) ? '0 : phase_inc[PERIOD_BITS-1:0];
      pending_next = pending_ff || (phase_next == '0);
      timer_next   = (timer_ff != '0) ? timer_ff - TIMER_BITS'(1) : timer_ff;
      step         = pending_next && cfg.enable;
      long_wide    = {17'd0, cfg.long_ms};
      timer_load   = (long_wide > TMAX) ? TMAX[TIMER_BITS-1:0] : long_wide[TIMER_BITS-1:0];
   end

   // press state machine: next state
   always_comb begin
      mode_in = mode_ff;
      if (item_take && step) begin
         unique case (mode_ff)
            MODE_INIT:         mode_in = MODE_WAIT_PRESS;
            MODE_WAIT_PRESS:   if (pressed) mode_in = MODE_PRESSED;
            MODE_PRESSED: begin
               if (timer_next == '0) mode_in = MODE_WAIT_RELEASE;
               else if (!pressed)    mode_in = MODE_WAIT_PRESS;
            end
            MODE_WAIT_RELEASE: if (!pressed) mode_in = MODE_WAIT_PRESS;
            default:           mode_in = MODE_INIT;
         endcase
      end
   end

   // press state machine: outputs
   always_comb begin
      ev       = EV_NONE;
      timer_in = timer_next;
      unique case (mode_ff)
         MODE_WAIT_PRESS: begin
            if (step && pressed) timer_in = timer_load;
         end
         MODE_PRESSED: begin
            if (step) begin
               if (timer_next == '0) ev = EV_LONG;
               else if (!pressed)    ev = EV_SHORT;
            end
         end
         default: ;
      endcase
      if (!item_take) timer_in = timer_ff;
   end

   // phase reduction after a period write, one shifted subtract per cycle
   always_comb begin
      norm_in    = norm_ff;
      shift_in   = shift_ff;
      phase_in   = phase_ff;
      pending_in = pending_ff;
      trial      = {{PERIOD_BITS{1'b0}}, period_eff} << shift_ff;
      if (norm_ff) begin
         if ({{PERIOD_BITS{1'b0}}, phase_ff} >= trial)
            phase_in = phase_ff - trial[PERIOD_BITS-1:0];
         if (shift_ff == '0) norm_in = 1'b0;
         else                shift_in = shift_ff - SHIFT_BITS'(1);
      end else if (cfg.period_wr) begin
         norm_in  = 1'b1;
         shift_in = SHIFT_BITS'(PERIOD_BITS - 1);
      end else if (item_take) begin
         phase_in   = phase_next;
         pending_in = pending_next && !cfg.enable;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      event_in     = event_ff;
      if (item_take) begin
         rsp_valid_in = 1'b1;
         event_in     = ev;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         pending_ff   <= 1'b0;
         timer_ff     <= '0;
         mode_ff      <= MODE_INIT;
         rsp_valid_ff <= 1'b0;
         norm_ff      <= 1'b0;
         shift_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         timer_ff     <= timer_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         norm_ff      <= norm_in;
         shift_ff     <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_press_event = event_ff;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the button short/long press detector
// Streams pin-level tick beats through the block and predicts one press event
// per tick from a cycle-free model of the debounce phase, press timer and
// press state machine. Register settings change between drained phases, and
// both channels idle at random, with one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import bslp_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int DRAIN_CYCLES = 12;
   localparam int TIMER_MAX    = (1 << TIMER_BITS_DEF) - 1;

   // index with no register behind it, writes are ignored
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [CSR_IDX_BITS-1:0] idx;
      logic [CSR_DAT_BITS-1:0] dat;
   } csr_write_t;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_pin_level = 1'b1;
   logic                    rsp_ready     = 1'b0;
   logic                    csr_valid     = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index     = '0;
   logic [CSR_DAT_BITS-1:0] csr_data      = '0;
   wire                     req_ready;
   wire                     rsp_valid;
   wire                     csr_ready;
   wire  [EVENT_BITS-1:0]   rsp_press_event;

   // pending pin ticks, pending register writes, predicted press events
   logic                  pin_ticks[$];
   csr_write_t            csr_writes[$];
   logic [EVENT_BITS-1:0] press_events[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int errors         = 0;
   int i;

   // predicted register and detector state
   logic                   en_m     = 1'b0;
   logic [PERIOD_BITS-1:0] period_m = RESET_PERIOD;
   logic [LONG_BITS-1:0]   long_m   = RESET_LONG;
   logic [PERIOD_BITS-1:0] phase_m  = '0;
   logic                   pend_m   = 1'b0;
   logic [TIMER_BITS_DEF-1:0] timer_m = '0;
   mode_type               mode_m   = MODE_INIT;

   button_short_long_press_detector_top uut (.*);

   // clock
   always #(CLK_HALF) clock = ~clock;

   // one millisecond tick of the detector, returns the press event
   function automatic logic [EVENT_BITS-1:0] detect_press(input logic pin);
      int                    per;
      logic                  pressed;
      logic [EVENT_BITS-1:0] ev;
      pressed = !pin;
      per     = (period_m == 0) ? 1 : int'(period_m);
      ev      = EV_NONE;
      phase_m = PERIOD_BITS'((int'(phase_m) + 1) % per);
      if (phase_m == 0) pend_m = 1'b1;
      if (timer_m != 0) timer_m = timer_m - TIMER_BITS_DEF'(1);
      if (pend_m && en_m) begin
         pend_m = 1'b0;
         case (mode_m)
            MODE_INIT: begin
               mode_m = MODE_WAIT_PRESS;
            end
            MODE_WAIT_PRESS: begin
               if (pressed) begin
                  timer_m = (int'(long_m) > TIMER_MAX) ? TIMER_BITS_DEF'(TIMER_MAX)
                                                       : TIMER_BITS_DEF'(long_m);
                  mode_m  = MODE_PRESSED;
               end
            end
            MODE_PRESSED: begin
               if (timer_m == 0) begin
                  ev     = EV_LONG;
                  mode_m = MODE_WAIT_RELEASE;
               end else if (!pressed) begin
                  ev     = EV_SHORT;
                  mode_m = MODE_WAIT_PRESS;
               end
            end
            default: begin
               if (!pressed) mode_m = MODE_WAIT_PRESS;
            end
         endcase
      end
      return ev;
   endfunction

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pin_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_pin_level <= pin_ticks.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (!csr_valid || csr_ready) begin
         if (csr_writes.size() != 0) begin
            csr_valid <= 1'b1;
            csr_index <= csr_writes[0].idx;
            csr_data  <= csr_writes[0].dat;
            void'(csr_writes.pop_front());
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   // result receiver, long hold-off counted here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: track register writes, predict per tick beat, check result beats
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE: en_m     = csr_data[0];
               CSR_PERIOD: period_m = csr_data[PERIOD_BITS-1:0];
               CSR_LONG:   long_m   = csr_data[LONG_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) press_events.push_back(detect_press(req_pin_level));
         if (rsp_valid && rsp_ready) begin
            if (press_events.size() == 0) begin
               $error("press_event beat with nothing expected, actual %0d", rsp_press_event);
               errors++;
            end else begin
               if (rsp_press_event !== press_events[0]) begin
                  $error("press_event expected %0d actual %0d", press_events[0],
                         rsp_press_event);
                  errors++;
               end
               void'(press_events.pop_front());
            end
         end
      end
   end

   // wait until the block has nothing in flight
   task automatic wait_drained();
      while (pin_ticks.size() != 0 || req_valid || press_events.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_regs(input int en, input int per, input int lng);
      csr_writes.push_back('{idx: CSR_ENABLE, dat: {15'($urandom), 1'(en)}});
      csr_writes.push_back('{idx: CSR_PERIOD, dat: {9'($urandom), 7'(per)}});
      csr_writes.push_back('{idx: CSR_LONG, dat: 16'(lng)});
      while (csr_writes.size() != 0 || csr_valid) @(negedge clock);
   endtask

   // button presses with bounce, short and long holds, plus raw noise
   task automatic queue_presses(input int n, input int per, input int lng);
      int made;
      int hold;
      int span;
      int per_eff;
      made    = 0;
      per_eff = (per == 0) ? 1 : per;
      span    = per_eff * (lng + 2);
      if (span > 300) span = 300;
      while (made < n) begin
         if ($urandom_range(99) < 80) begin
            repeat ($urandom_range(0, 3)) begin
               pin_ticks.push_back(1'($urandom_range(1)));
               made++;
            end
            hold = $urandom_range(1) ? $urandom_range(1, span)
                                     : span + $urandom_range(0, 2 * per_eff + 2);
            repeat (hold) pin_ticks.push_back(1'b0);
            made += hold;
            hold = $urandom_range(1, 3 * per_eff + 2);
            repeat (hold) pin_ticks.push_back(1'b1);
            made += hold;
         end else begin
            repeat ($urandom_range(1, 8)) begin
               pin_ticks.push_back(1'($urandom_range(1)));
               made++;
            end
         end
      end
      // keep the phase at its planned length
      while (made > n) begin
         void'(pin_ticks.pop_back());
         made--;
      end
   endtask

   task automatic run_phase(input int en, input int per, input int lng,
                            input int send, input int recv, input int n);
      wait_drained();
      write_regs(en, per, lng);
      send_idle_pct  = send;
      recv_stall_pct = recv;
      queue_presses(n, per, lng);
   endtask

   // stimulus
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // disabled at reset values: the pending sample is raised and held
      for (i = 0; i < 15; i++) pin_ticks.push_back(1'(i));
      wait_drained();

      // period shrinks below the phase, zero long press time
      write_regs(1, 2, 0);
      pin_ticks.push_back(1'b1);
      repeat (5) pin_ticks.push_back(1'b0);
      repeat (3) pin_ticks.push_back(1'b1);

      run_phase(1, 1, 0, 0, 0, 150);
      run_phase(1, 3, 5, 85, 0, 200);
      run_phase(1, 10, 12, 0, 85, 250);
      // result side holds off while ticks keep coming
      hold_left = 150;
      run_phase(1, 1, 65535, 34, 34, 150);
      run_phase(0, 2, 4, 0, 0, 100);
      run_phase(1, 100, 1, 85, 85, 200);
      wait_drained();
      csr_writes.push_back('{idx: CSR_UNUSED, dat: 16'($urandom)});
      run_phase(1, 0, 3, 34, 34, 150);
      run_phase(1, 127, 2, 0, 0, 150);
      run_phase(1, 7, 30, 34, 34, 100);

      wait_drained();
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
